// ===== sv/dq_pkg.sv =====
// Package for the double-ended queue: depth, widths, request kinds,
// status codes, cell commands and the structs passed between cells.
// No dependencies.
`default_nettype none

package dq_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STAT_W  = 2;

  // request kinds, codes above KIND_QUERY act as query
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [DATA_W-1:0]  push_value;
  } cell_ctrl_t;

  // contents of a neighboring cell
  typedef struct packed {
    logic               vld;
    logic [DATA_W-1:0]  val;
  } cell_data_t;

endpackage

`default_nettype wire

// ===== sv/dq_cell.sv =====
// One storage cell of the deque chain: holds one element and its occupied
// flag, shifting to or from its neighbors on push front and pop front and
// changing only at the end on push back and pop back. Depends on dq_pkg.
`default_nettype none

module dq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dq_pkg::cell_ctrl_t ctrl_i,
  input  dq_pkg::cell_data_t prev_i,
  input  dq_pkg::cell_data_t next_i,
  output dq_pkg::cell_data_t cur_o,
  output logic               last_o
);
  import dq_pkg::*;

  logic              vld_q, vld_d;
  logic [DATA_W-1:0] val_q, val_d;

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    case (ctrl_i.op)
      OP_PUSH_FRONT: begin
        vld_d = prev_i.vld;
        val_d = prev_i.val;
      end
      OP_PUSH_BACK: begin
        // first free cell takes the value
        if (!vld_q && prev_i.vld) begin
          vld_d = 1'b1;
          val_d = ctrl_i.push_value;
        end
      end
      OP_POP_FRONT: begin
        vld_d = next_i.vld;
        val_d = next_i.val;
      end
      OP_POP_BACK: begin
        if (vld_q && !next_i.vld) begin
          vld_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign cur_o.vld = vld_q;
  assign cur_o.val = val_q;
  assign last_o    = vld_q && !next_i.vld;

endmodule

`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// Top level of the bounded double-ended queue: request decode, cell chain,
// element count and result register. Depends on dq_pkg and dq_cell.
//
// Elements sit in a chain of DEPTH cells, front in cell 0 and packed toward
// it; a push front or pop front shifts every cell by one position in the
// cycle the request is accepted, push back and pop back touch only the end
// of the chain. Each request goes through the chain update, then the
// front/back read into the result register, before its result shows, and
// the next request is taken once that result has been accepted. A pop
// on an empty queue reports underflow, a push on a full one reports
// overflow, and neither changes the contents.
`default_nettype none

module double_ended_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dq_pkg::KIND_W-1:0]   kind_i,
  input  logic signed [dq_pkg::DATA_W-1:0] push_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [dq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [dq_pkg::DATA_W-1:0] back_value_o,
  output logic [dq_pkg::CNT_W-1:0]    count_o,
  output logic                        is_empty_o,
  output logic [dq_pkg::STAT_W-1:0]   status_o
);
  import dq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic              accept;
  logic              full, empty;
  cell_op_e          op;
  cell_ctrl_t        ctrl;
  logic [STAT_W-1:0] status_d, status_q;
  logic [CNT_W-1:0]  count_q, count_d;

  cell_data_t        cur  [DEPTH];
  cell_data_t        prev [DEPTH];
  cell_data_t        next [DEPTH];
  logic [DEPTH-1:0]  last;

  logic [DATA_W-1:0] back_sel;
  logic [DATA_W-1:0] front_q, back_q;
  logic [CNT_W-1:0]  cnt_out_q;
  logic [STAT_W-1:0] stat_out_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = cur[DEPTH-1].vld;
  assign empty      = !cur[0].vld;

  // decode the request against full and empty
  always_comb begin
    op       = OP_HOLD;
    status_d = STAT_OK;
    count_d  = count_q;
    case (kind_i) inside
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (full) begin
          status_d = STAT_OVERFLOW;
        end else begin
          op      = (kind_i == KIND_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
          count_d = count_q + 1'b1;
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (empty) begin
          status_d = STAT_UNDERFLOW;
        end else begin
          op      = (kind_i == KIND_POP_FRONT) ? OP_POP_FRONT : OP_POP_BACK;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctrl.op         = accept ? op : OP_HOLD;
  assign ctrl.push_value = push_value_i;

  // neighbor wiring, cell 0 sees the new value on push front
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev[i].vld = 1'b1;
      assign prev[i].val = push_value_i;
    end else begin : g_mid
      assign prev[i] = cur[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign next[i].vld = 1'b0;
      assign next[i].val = '0;
    end else begin : g_inner
      assign next[i] = cur[i+1];
    end

    dq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .prev_i (prev[i]),
      .next_i (next[i]),
      .cur_o  (cur[i]),
      .last_o (last[i])
    );
  end

  // last is one-hot or zero
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_sel = back_sel | (last[i] ? cur[i].val : '0);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept)      state_d = ST_CALC;
      ST_CALC:                  state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default:                  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
    if (state_q == ST_CALC) begin
      front_q    <= cur[0].vld ? cur[0].val : '0;
      back_q     <= back_sel;
      cnt_out_q  <= count_q;
      stat_out_q <= status_q;
    end
  end

  assign out_valid_o   = (state_q == ST_OUT);
  assign front_value_o = front_q;
  assign back_value_o  = back_q;
  assign count_o       = cnt_out_q;
  assign is_empty_o    = (cnt_out_q == '0);
  assign status_o      = stat_out_q;

endmodule

`default_nettype wire

// ===== sv/dq_checker.sv =====
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on dq_pkg and double_ended_queue.
`default_nettype none

module dq_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [dq_pkg::DATA_W-1:0]   front_value_o,
  input  logic [dq_pkg::DATA_W-1:0]   back_value_o,
  input  logic [dq_pkg::CNT_W-1:0]    count_o,
  input  logic                        is_empty_o,
  input  logic [dq_pkg::STAT_W-1:0]   status_o
);
  import dq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(front_value_o)
      && $stable(back_value_o) && $stable(count_o) && $stable(status_o))
    else $error("result changed while stalled");

  // no result in the cycle after a request is taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result shown before chain update");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (count_o == '0)) && (count_o <= CNT_W'(DEPTH)))
    else $error("count or empty flag inconsistent");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> front_value_o == '0 && back_value_o == '0)
    else $error("empty queue shows nonzero value");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == STAT_OK || status_o == STAT_UNDERFLOW
      || status_o == STAT_OVERFLOW)
    else $error("bad status code");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .front_value_o (front_value_o),
  .back_value_o  (back_value_o),
  .count_o       (count_o),
  .is_empty_o    (is_empty_o),
  .status_o      (status_o)
);

`default_nettype wire
